### rtl/mtrr_pkg.sv
// shared types and constants for the mtrr memory type resolver
package mtrr_pkg;

   localparam logic [2:0] TYPE_UC = 3'd0;
   localparam logic [2:0] TYPE_WC = 3'd1;
   localparam logic [2:0] TYPE_WT = 3'd4;
   localparam logic [2:0] TYPE_WP = 3'd5;
   localparam logic [2:0] TYPE_WB = 3'd6;

   localparam int FIXED_REGS = 11;

   localparam logic [11:0] MSR_DEF_TYPE = 12'h2FF;
   localparam logic [11:0] MSR_FIX_64K = 12'h250;
   localparam logic [11:0] MSR_FIX_16K_LO = 12'h258;
   localparam logic [11:0] MSR_FIX_16K_HI = 12'h259;
   localparam logic [11:0] MSR_FIX_4K_FIRST = 12'h268;
   localparam logic [11:0] MSR_FIX_4K_LAST = 12'h26F;
   localparam logic [11:0] MSR_VAR_FIRST = 12'h200;
   localparam logic [11:0] MSR_VAR_LAST = 12'h213;

   localparam logic [19:0] END_64K = 20'h7ffff;
   localparam logic [19:0] END_16K_LO = 20'h9ffff;
   localparam logic [19:0] END_16K_HI = 20'hbffff;
   localparam logic [19:0] END_4K_FIRST = 20'hc7fff;
   localparam logic [19:0] END_FIXED = 20'hfffff;

   localparam logic [0:0] CSR_VAR_COUNT = 1'b0;
   localparam logic [0:0] CSR_FIXED_SUP = 1'b1;

   // classified operation kinds
   localparam logic [2:0] CMD_REJECT = 3'd0;
   localparam logic [2:0] CMD_DEF = 3'd1;
   localparam logic [2:0] CMD_FIXED = 3'd2;
   localparam logic [2:0] CMD_BASE = 3'd3;
   localparam logic [2:0] CMD_MASK = 3'd4;
   localparam logic [2:0] CMD_LOOKUP = 3'd5;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [3:0]  slot;
      logic [63:0] value;
      logic [51:0] addr;
   } cmd_type;

   function automatic logic type_ok(input logic [7:0] t);
      return t == {5'd0, TYPE_UC} || t == {5'd0, TYPE_WC} || t == {5'd0, TYPE_WT}
         || t == {5'd0, TYPE_WP} || t == {5'd0, TYPE_WB};
   endfunction

endpackage

### rtl/mtrr_front.sv
// front end: decodes and validates each request into a command
module mtrr_front #(
   parameter int VAR_RANGES = 10
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic              operation,
   input  logic [11:0]       msr_number,
   input  logic [63:0]       write_value,
   input  logic [51:0]       lookup_address,
   output logic              q_valid,
   input  logic              q_ready,
   output mtrr_pkg::cmd_type q_cmd
);
   localparam int QD = 2;

   mtrr_pkg::cmd_type q_ff [QD];
   mtrr_pkg::cmd_type q_in;
   logic              wp_ff, rp_ff;
   logic [1:0]        cnt_ff;
   logic              all_ok;
   logic [11:0]       voff;
   logic              push, pop;

   always_comb begin
      all_ok = 1'b1;
      for (int k = 0; k < 8; k++)
         if (!mtrr_pkg::type_ok(write_value[8*k +: 8])) all_ok = 1'b0;
      voff = msr_number - mtrr_pkg::MSR_VAR_FIRST;
      q_in.cmd = mtrr_pkg::CMD_REJECT;
      q_in.slot = 4'd0;
      q_in.value = write_value;
      q_in.addr = lookup_address;
      if (operation) begin
         q_in.cmd = mtrr_pkg::CMD_LOOKUP;
      end else if (msr_number == mtrr_pkg::MSR_DEF_TYPE) begin
         if (write_value[9:8] == 2'b00 && write_value[63:12] == '0
               && mtrr_pkg::type_ok(write_value[7:0]))
            q_in.cmd = mtrr_pkg::CMD_DEF;
      end else if (msr_number == mtrr_pkg::MSR_FIX_64K) begin
         if (all_ok) q_in.cmd = mtrr_pkg::CMD_FIXED;
      end else if (msr_number == mtrr_pkg::MSR_FIX_16K_LO) begin
         q_in.slot = 4'd1;
         if (all_ok) q_in.cmd = mtrr_pkg::CMD_FIXED;
      end else if (msr_number == mtrr_pkg::MSR_FIX_16K_HI) begin
         q_in.slot = 4'd2;
         if (all_ok) q_in.cmd = mtrr_pkg::CMD_FIXED;
      end else if (msr_number >= mtrr_pkg::MSR_FIX_4K_FIRST
            && msr_number <= mtrr_pkg::MSR_FIX_4K_LAST) begin
         q_in.slot = 4'd3 + {1'b0, msr_number[2:0]};
         if (all_ok) q_in.cmd = mtrr_pkg::CMD_FIXED;
      end else if (msr_number >= mtrr_pkg::MSR_VAR_FIRST
            && msr_number <= mtrr_pkg::MSR_VAR_LAST) begin
         q_in.slot = voff[4:1];
         if ({28'd0, voff[4:1]} < VAR_RANGES) begin
            if (!msr_number[0]) begin
               if (write_value[11:8] == 4'd0 && write_value[63:52] == '0
                     && mtrr_pkg::type_ok(write_value[7:0]))
                  q_in.cmd = mtrr_pkg::CMD_BASE;
            end else if (write_value[10:0] == '0 && write_value[63:52] == '0) begin
               q_in.cmd = mtrr_pkg::CMD_MASK;
            end
         end
      end
   end

   assign in_ready = cnt_ff != 2'(QD);
   assign q_valid = cnt_ff != 2'd0;
   assign q_cmd = q_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop = q_valid && q_ready;

   always_ff @(posedge clock) begin
      if (push) q_ff[wp_ff] <= q_in;
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= !wp_ff;
         if (pop) rp_ff <= !rp_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end
endmodule

### rtl/mtrr_back.sv
// back end: register file, fixed lookup and iterative variable range walk
module mtrr_back #(
   parameter int VAR_RANGES = 10
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   output logic              q_ready,
   input  mtrr_pkg::cmd_type q_cmd,
   input  logic [3:0]        var_count,
   input  logic              fixed_sup,
   output logic              out_valid,
   input  logic              out_ready,
   output logic              out_accepted,
   output logic [2:0]        out_type,
   output logic              out_conflict
);
   localparam int IW = $clog2(VAR_RANGES + 1);
   localparam int AW = (VAR_RANGES > 1) ? $clog2(VAR_RANGES) : 1;
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_WALK = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [11:0] def_ff;
   logic [63:0] fix_ff [mtrr_pkg::FIXED_REGS];
   logic [63:0] base_ff [VAR_RANGES];
   logic [63:0] mask_ff [VAR_RANGES];

   logic [1:0]  st_ff, st_in;
   logic [IW-1:0] i_ff, n_ff;
   logic [51:0] a_ff;
   logic [7:0]  bm_ff, bm_in;
   logic [2:0]  last_ff, last_in;
   logic        ov_ff, oacc_ff, oconf_ff;
   logic [2:0]  otype_ff;
   logic        rv_ff;  // a command is in flight or its result is pending in the output register
   logic [3:0]  freg, fsub;
   logic [63:0] fword;
   logic [2:0]  ftype, vtype;
   logic        vconf, hit;
   logic [IW-1:0] nsel;
   logic [19:0] a20;
   logic [51:0] m, b;

   assign out_valid = ov_ff;
   assign out_accepted = oacc_ff;
   assign out_type = otype_ff;
   assign out_conflict = oconf_ff;
   assign q_ready = st_ff == ST_IDLE && !rv_ff;

   always_comb begin
      a20 = q_cmd.addr[19:0];
      fsub = {1'b0, a20[14:12]};
      if (a20 <= mtrr_pkg::END_64K) begin
         freg = 4'd0;
         fsub = {1'b0, a20[18:16]};
      end else if (a20 <= mtrr_pkg::END_16K_LO) begin
         freg = 4'd1;
         fsub = {1'b0, a20[16:14]};
      end else if (a20 <= mtrr_pkg::END_16K_HI) begin
         freg = 4'd2;
         fsub = {1'b0, a20[16:14]};
      end else begin
         freg = 4'd3 + {1'b0, a20[17:15]};
      end
      fword = fix_ff[freg];
      ftype = fword[8*fsub[2:0] +: 3];
   end

   always_comb begin
      nsel = (var_count > 4'(VAR_RANGES)) ? IW'(VAR_RANGES) : IW'(var_count);
      m = {mask_ff[i_ff[AW-1:0]][51:12], 12'd0};
      b = {base_ff[i_ff[AW-1:0]][51:12], 12'd0};
      hit = mask_ff[i_ff[AW-1:0]][11] && ((b & m) == (a_ff & m));
      bm_in = bm_ff;
      last_in = last_ff;
      if (hit) begin
         last_in = base_ff[i_ff[AW-1:0]][2:0];
         bm_in = bm_ff | (8'd1 << last_in);
      end
      vconf = 1'b0;
      if (bm_ff == 8'd0) vtype = def_ff[2:0];
      else if ((bm_ff & (bm_ff - 8'd1)) == 8'd0) vtype = last_ff;
      else if (bm_ff[0]) vtype = mtrr_pkg::TYPE_UC;
      else if (bm_ff == 8'b0101_0000) vtype = mtrr_pkg::TYPE_WT;
      else begin
         vtype = mtrr_pkg::TYPE_UC;
         vconf = 1'b1;
      end
      st_in = st_ff;
      case (st_ff)
         ST_IDLE: if (q_valid && q_ready && q_cmd.cmd == mtrr_pkg::CMD_LOOKUP
               && def_ff[11] && !(fixed_sup && def_ff[10]
               && q_cmd.addr <= {32'd0, mtrr_pkg::END_FIXED}))
            st_in = ST_WALK;
         ST_WALK: if (i_ff >= n_ff) st_in = ST_DONE;
         ST_DONE: st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         ov_ff <= 1'b0;
         rv_ff <= 1'b0;
         def_ff <= '0;
         for (int k = 0; k < mtrr_pkg::FIXED_REGS; k++) fix_ff[k] <= '0;
         for (int k = 0; k < VAR_RANGES; k++) begin
            base_ff[k] <= '0;
            mask_ff[k] <= '0;
         end
      end else begin
         st_ff <= st_in;
         if (ov_ff && out_ready) begin
            ov_ff <= 1'b0;
            rv_ff <= 1'b0;
         end
         if (q_valid && q_ready) begin
            a_ff <= q_cmd.addr;
            i_ff <= '0;
            n_ff <= nsel;
            bm_ff <= '0;
            last_ff <= '0;
            oacc_ff <= 1'b0;
            otype_ff <= mtrr_pkg::TYPE_UC;
            oconf_ff <= 1'b0;
            case (q_cmd.cmd)
               mtrr_pkg::CMD_DEF: def_ff <= q_cmd.value[11:0];
               mtrr_pkg::CMD_FIXED: fix_ff[q_cmd.slot] <= q_cmd.value;
               mtrr_pkg::CMD_BASE: base_ff[q_cmd.slot[AW-1:0]] <= q_cmd.value;
               mtrr_pkg::CMD_MASK: mask_ff[q_cmd.slot[AW-1:0]] <= q_cmd.value;
               default: ;
            endcase
            if (q_cmd.cmd != mtrr_pkg::CMD_LOOKUP) begin
               oacc_ff <= q_cmd.cmd != mtrr_pkg::CMD_REJECT;
               ov_ff <= 1'b1;
               rv_ff <= 1'b1;
            end else if (st_in == ST_IDLE) begin
               // disabled or fixed range hit resolves at once
               if (def_ff[11]) otype_ff <= ftype;
               ov_ff <= 1'b1;
               rv_ff <= 1'b1;
            end else begin
               rv_ff <= 1'b1;
            end
         end
         if (st_ff == ST_WALK && i_ff < n_ff) begin
            bm_ff <= bm_in;
            last_ff <= last_in;
            i_ff <= i_ff + IW'(1);
         end
         if (st_ff == ST_DONE) begin
            otype_ff <= vtype;
            oconf_ff <= vconf;
            ov_ff <= 1'b1;
         end
      end
   end
endmodule

### rtl/mtrr_memory_type_resolver.sv
// top level of the mtrr memory type resolver
// usage:
//   requests enter as a queue: an item beats in when req_push is high and
//   req_full is low. operation 0 writes the range register named by
//   req_msr_number, operation 1 resolves req_lookup_address.
//   every request yields one response beat, popped with rsp_pop while
//   rsp_empty is low, in request order.
//   a front stage decodes and validates requests into a two-entry command
//   queue; the back stage owns the registers and walks the variable ranges
//   one pair per cycle.
//   a write, a disabled lookup or a fixed-range lookup passes the command
//   queue and is resolved into the output register as the back stage takes
//   it; a variable lookup walks the examined ranges, then a done state loads
//   the output register. the back stage handles one command at a time and
//   takes the next one the cycle after the response is popped.
//   the csr channel (always ready) sets the variable range count and the
//   fixed-range capability bit; write it only while the block is idle.
//   reset clears all range registers, the count to 8 and the capability to 1.
//   if the receiver stalls, the response holds and the queue fills, then
//   req_full rises.
module mtrr_memory_type_resolver #(
   parameter int VAR_RANGES = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic        req_operation,
   input  logic [11:0] req_msr_number,
   input  logic [63:0] req_write_value,
   input  logic [51:0] req_lookup_address,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic        rsp_write_accepted,
   output logic [2:0]  rsp_memory_type,
   output logic        rsp_type_conflict,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [3:0]  csr_data
);
   logic              in_ready, q_valid, q_ready, out_valid;
   mtrr_pkg::cmd_type q_cmd;
   logic [3:0]        count_ff;
   logic              fsup_ff;

   assign csr_ready = 1'b1;
   assign req_full = !in_ready;
   assign rsp_empty = !out_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 4'd8;
         fsup_ff <= 1'b1;
      end else if (csr_valid) begin
         if (csr_index == mtrr_pkg::CSR_VAR_COUNT) count_ff <= csr_data;
         else if (csr_index == mtrr_pkg::CSR_FIXED_SUP) fsup_ff <= csr_data[0];
      end
   end

   mtrr_front #(.VAR_RANGES(VAR_RANGES)) u_front (
      .clock, .reset, .in_valid(req_push), .in_ready,
      .operation(req_operation), .msr_number(req_msr_number),
      .write_value(req_write_value), .lookup_address(req_lookup_address),
      .q_valid, .q_ready, .q_cmd
   );

   mtrr_back #(.VAR_RANGES(VAR_RANGES)) u_back (
      .clock, .reset, .q_valid, .q_ready, .q_cmd,
      .var_count(count_ff), .fixed_sup(fsup_ff),
      .out_valid, .out_ready(rsp_pop), .out_accepted(rsp_write_accepted),
      .out_type(rsp_memory_type), .out_conflict(rsp_type_conflict)
   );
endmodule

### rtl/mtrr_checker.sv
// port-level assertions for the mtrr memory type resolver, with bind
module mtrr_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_empty,
   input logic       rsp_pop,
   input logic       rsp_write_accepted,
   input logic [2:0] rsp_memory_type,
   input logic       rsp_type_conflict
);
   // a stalled response beat holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_memory_type))
      else $error("response changed while stalled");
   a_conf: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_type_conflict |-> rsp_memory_type == 3'd0
         && !rsp_write_accepted)
      else $error("conflict with nonzero type");
   a_wr: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_write_accepted |-> rsp_memory_type == 3'd0)
      else $error("write response carries a type");
   a_rst: assert property (@(posedge clock) $past(reset) |-> rsp_empty)
      else $error("response after reset");
endmodule

bind mtrr_memory_type_resolver mtrr_checker u_checker (.*);

### tb/testbench.sv
// self-checking testbench for the mtrr memory type resolver
module testbench;

   typedef struct {
      logic       accepted;
      logic [2:0] type_code;
      logic       conflict;
   } rsp_beat_type;

   class resolver_scoreboard_type;
      logic [3:0]  range_count = 4'd8;
      logic        fixed_sup = 1'b1;
      logic [11:0] def_type = '0;
      logic [63:0] fixed_word [mtrr_pkg::FIXED_REGS];
      logic [63:0] var_base [10];
      logic [63:0] var_mask [10];
      rsp_beat_type expected_rsp [$];
      int          errors = 0;
      int          n_requests = 0;
      int          n_accepted = 0;
      int          n_lookups = 0;
      int          n_conflicts = 0;

      function new();
         foreach (fixed_word[i]) fixed_word[i] = '0;
         foreach (var_base[i]) begin
            var_base[i] = '0;
            var_mask[i] = '0;
         end
      endfunction

      function bit legal_type(logic [7:0] t);
         return t == {5'd0, mtrr_pkg::TYPE_UC} || t == {5'd0, mtrr_pkg::TYPE_WC}
            || t == {5'd0, mtrr_pkg::TYPE_WT} || t == {5'd0, mtrr_pkg::TYPE_WP}
            || t == {5'd0, mtrr_pkg::TYPE_WB};
      endfunction

      function bit store_register(logic [11:0] msr, logic [63:0] v);
         int slot;
         int idx;
         slot = -1;
         if (msr == mtrr_pkg::MSR_DEF_TYPE) begin
            if (v[9:8] != 0 || v[63:12] != 0 || !legal_type(v[7:0])) return 0;
            def_type = v[11:0];
            return 1;
         end
         if (msr == mtrr_pkg::MSR_FIX_64K) slot = 0;
         else if (msr == mtrr_pkg::MSR_FIX_16K_LO) slot = 1;
         else if (msr == mtrr_pkg::MSR_FIX_16K_HI) slot = 2;
         else if (msr >= mtrr_pkg::MSR_FIX_4K_FIRST && msr <= mtrr_pkg::MSR_FIX_4K_LAST)
            slot = 3 + int'(msr - mtrr_pkg::MSR_FIX_4K_FIRST);
         if (slot >= 0) begin
            for (int k = 0; k < 8; k++)
               if (!legal_type(v[8*k +: 8])) return 0;
            fixed_word[slot] = v;
            return 1;
         end
         if (msr >= mtrr_pkg::MSR_VAR_FIRST && msr <= mtrr_pkg::MSR_VAR_LAST) begin
            idx = int'(msr - mtrr_pkg::MSR_VAR_FIRST) >> 1;
            if (!msr[0]) begin
               if (v[11:8] != 0 || v[63:52] != 0 || !legal_type(v[7:0])) return 0;
               var_base[idx] = v;
            end else begin
               if (v[10:0] != 0 || v[63:52] != 0) return 0;
               var_mask[idx] = v;
            end
            return 1;
         end
         return 0;
      endfunction

      function logic [2:0] fixed_type(logic [19:0] a);
         int word;
         logic [19:0] off;
         logic [2:0] sub;
         if (a <= mtrr_pkg::END_64K) begin
            word = 0;
            sub = a[18:16];
         end else if (a <= mtrr_pkg::END_16K_LO) begin
            off = a - 20'h80000;
            word = 1;
            sub = off[16:14];
         end else if (a <= mtrr_pkg::END_16K_HI) begin
            off = a - 20'ha0000;
            word = 2;
            sub = off[16:14];
         end else begin
            off = a - 20'hc0000;
            word = 3 + int'(off >> 15);
            sub = a[14:12];
         end
         return fixed_word[word][8*sub +: 3];
      endfunction

      function rsp_beat_type resolve_type(logic [51:0] a);
         rsp_beat_type r;
         logic [7:0] seen;
         logic [2:0] last;
         logic [51:0] m, b;
         int n;
         r = '{1'b0, mtrr_pkg::TYPE_UC, 1'b0};
         seen = '0;
         last = mtrr_pkg::TYPE_UC;
         if (!def_type[11]) return r;
         if (fixed_sup && def_type[10] && a <= 52'(mtrr_pkg::END_FIXED)) begin
            r.type_code = fixed_type(a[19:0]);
            return r;
         end
         n = range_count > 10 ? 10 : range_count;
         for (int i = 0; i < n; i++) begin
            if (!var_mask[i][11]) continue;
            m = {var_mask[i][51:12], 12'h0};
            b = {var_base[i][51:12], 12'h0};
            if ((b & m) == (a & m)) begin
               last = var_base[i][2:0];
               seen[last] = 1'b1;
            end
         end
         if (seen == 0) r.type_code = def_type[2:0];
         else if ((seen & (seen - 8'd1)) == 0) r.type_code = last;
         else if (seen[mtrr_pkg::TYPE_UC]) r.type_code = mtrr_pkg::TYPE_UC;
         else if (seen == ((8'd1 << mtrr_pkg::TYPE_WT) | (8'd1 << mtrr_pkg::TYPE_WB)))
            r.type_code = mtrr_pkg::TYPE_WT;
         else r.conflict = 1'b1;
         return r;
      endfunction

      function void note_request(logic op, logic [11:0] msr, logic [63:0] v,
                                 logic [51:0] a);
         rsp_beat_type r;
         n_requests++;
         if (!op) begin
            r = '{store_register(msr, v), mtrr_pkg::TYPE_UC, 1'b0};
            n_accepted += r.accepted;
         end else begin
            r = resolve_type(a);
            n_lookups++;
            n_conflicts += r.conflict;
         end
         expected_rsp.push_back(r);
      endfunction

      function void check_response(logic wa, logic [2:0] mt, logic tc);
         rsp_beat_type e;
         if (expected_rsp.size() == 0) begin
            $error("response beat with nothing outstanding");
            errors++;
            return;
         end
         e = expected_rsp.pop_front();
         if (wa !== e.accepted) begin
            $error("write_accepted: expected %0d, got %0d", e.accepted, wa);
            errors++;
         end
         if (mt !== e.type_code) begin
            $error("memory_type: expected %0d, got %0d", e.type_code, mt);
            errors++;
         end
         if (tc !== e.conflict) begin
            $error("type_conflict: expected %0d, got %0d", e.conflict, tc);
            errors++;
         end
      endfunction

      function void set_csr(logic [0:0] idx, logic [3:0] data);
         if (idx == mtrr_pkg::CSR_VAR_COUNT) range_count = data;
         else fixed_sup = data[0];
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_push;
   logic        req_full;
   logic        req_operation;
   logic [11:0] req_msr_number;
   logic [63:0] req_write_value;
   logic [51:0] req_lookup_address;
   logic        rsp_empty;
   logic        rsp_pop;
   logic        rsp_write_accepted;
   logic [2:0]  rsp_memory_type;
   logic        rsp_type_conflict;
   logic        csr_valid;
   logic        csr_ready;
   logic [0:0]  csr_index;
   logic [3:0]  csr_data;

   resolver_scoreboard_type sb = new();
   bit quiet = 0;
   bit hold_rsp = 0;
   int settings_seen = 0;

   mtrr_memory_type_resolver uut (.*);

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("timeout waiting for responses");
      $display("mtrr_memory_type_resolver regression: fail");
      $finish;
   end

   // response side: random pop bursts plus one long hold-off
   initial begin
      int stall_left;
      int held;
      stall_left = 0;
      held = 0;
      rsp_pop = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_pop && !rsp_empty)
            sb.check_response(rsp_write_accepted, rsp_memory_type, rsp_type_conflict);
         if (hold_rsp) begin
            rsp_pop <= 1'b0;
            held++;
            if (held == 120) begin
               hold_rsp = 0;
               held = 0;
            end
         end else if (stall_left > 0) begin
            rsp_pop <= 1'b0;
            stall_left--;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_pop <= 1'b0;
            stall_left = $urandom_range(0, 9);
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [7:0] rand_type();
      logic [2:0] pick [5] = '{mtrr_pkg::TYPE_UC, mtrr_pkg::TYPE_WC, mtrr_pkg::TYPE_WT,
                               mtrr_pkg::TYPE_WP, mtrr_pkg::TYPE_WB};
      return {5'd0, pick[$urandom_range(0, 4)]};
   endfunction

   task automatic send(logic op, logic [11:0] msr, logic [63:0] v, logic [51:0] a);
      req_push <= 1'b1;
      req_operation <= op;
      req_msr_number <= msr;
      req_write_value <= v;
      req_lookup_address <= a;
      do @(posedge clock); while (req_full);
      sb.note_request(op, msr, v, a);
   endtask

   task automatic write_reg(logic [11:0] msr, logic [63:0] v);
      send(1'b0, msr, v, 52'(rand64()));
   endtask

   task automatic look_up(logic [51:0] a);
      send(1'b1, 12'($urandom), rand64(), a);
   endtask

   task automatic idle(int n);
      req_push <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_push <= 1'b0;
      while (sb.expected_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic csr_write(logic [0:0] idx, logic [3:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.set_csr(idx, data);
      @(posedge clock);
   endtask

   task automatic random_request();
      int pick;
      int idx;
      int k;
      logic [39:0] region;
      logic [39:0] mask40;
      logic [51:0] m;
      logic [51:0] a;
      logic [63:0] v;
      pick = $urandom_range(0, 99);
      idx = $urandom_range(0, 9);
      if (pick < 30) begin
         if ($urandom_range(0, 1)) begin
            region = $urandom_range(0, 2) == 0 ? 40'(rand64())
                                               : 40'($urandom_range(0, 3)) << 8;
            write_reg(mtrr_pkg::MSR_VAR_FIRST + 12'(2 * idx),
                      {12'h0, region, 4'h0, rand_type()});
         end else begin
            k = $urandom_range(0, 39);
            mask40 = ~40'h0 << k;
            write_reg(mtrr_pkg::MSR_VAR_FIRST + 12'(2 * idx + 1),
                      {12'h0, mask40, ($urandom_range(0, 4) != 0), 11'h0});
         end
      end else if (pick < 40) begin
         if ($urandom_range(0, 2) == 0) begin
            v = {52'h0, ($urandom_range(0, 7) != 0), 1'($urandom), 2'b00, rand_type()};
            write_reg(mtrr_pkg::MSR_DEF_TYPE, v);
         end else begin
            for (int b = 0; b < 8; b++) v[8*b +: 8] = rand_type();
            k = $urandom_range(0, 10);
            write_reg(k == 0 ? mtrr_pkg::MSR_FIX_64K : k == 1 ? mtrr_pkg::MSR_FIX_16K_LO :
                      k == 2 ? mtrr_pkg::MSR_FIX_16K_HI
                             : mtrr_pkg::MSR_FIX_4K_FIRST + 12'(k - 3), v);
         end
      end else if (pick < 55) begin
         look_up(52'($urandom_range(0, 'hfffff)));
      end else if (pick < 75) begin
         m = {sb.var_mask[idx][51:12], 12'h0};
         a = 52'(rand64());
         look_up(({sb.var_base[idx][51:12], 12'h0} & m) | (a & ~m));
      end else if (pick < 85) begin
         look_up(52'(rand64()));
      end else begin
         // malformed or unknown register writes, occasional bare lookups
         v = rand64();
         if ($urandom_range(0, 3) == 0) v[7:0] = 8'($urandom_range(0, 7));
         send(1'($urandom_range(0, 3) == 0),
              $urandom_range(0, 1) ? 12'($urandom) : 12'($urandom_range('h1f0, 'h2ff)),
              v, 52'(rand64()));
      end
   endtask

   initial begin
      logic [3:0] counts [6] = '{4'd10, 4'd0, 4'd15, 4'd8, 4'd1, 4'd10};
      logic       sups [6] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
      int wait_cycles;
      reset = 1;
      req_push = 0;
      req_operation = 0;
      req_msr_number = '0;
      req_write_value = '0;
      req_lookup_address = '0;
      csr_valid = 0;
      csr_index = '0;
      csr_data = '0;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: disabled, default register checks, fixed table corners
      look_up(52'h0);
      write_reg(mtrr_pkg::MSR_DEF_TYPE, 64'hC06);
      write_reg(mtrr_pkg::MSR_DEF_TYPE, 64'h306);
      write_reg(mtrr_pkg::MSR_DEF_TYPE, 64'h1C06);
      write_reg(mtrr_pkg::MSR_DEF_TYPE, 64'hC02);
      write_reg(mtrr_pkg::MSR_FIX_64K, 64'h0001_0405_0606_0504);
      write_reg(mtrr_pkg::MSR_FIX_16K_LO, 64'h0606_0606_0606_0606);
      write_reg(mtrr_pkg::MSR_FIX_16K_HI, 64'h0101_0101_0101_0101);
      write_reg(mtrr_pkg::MSR_FIX_4K_FIRST, 64'h0405_0601_0004_0506);
      write_reg(mtrr_pkg::MSR_FIX_4K_LAST, 64'h0606_0606_0606_0600);
      write_reg(mtrr_pkg::MSR_FIX_4K_FIRST + 12'd1, 64'h0706_0606_0606_0606);
      look_up(52'h7ffff);
      look_up(52'h80000);
      look_up(52'hbffff);
      look_up(52'hc0000);
      look_up(52'hfffff);
      // variable ranges: wt plus wb, uc overlap, conflict, bad encodings
      write_reg(12'h200, 64'h10_0004);
      write_reg(12'h201, 64'h000F_FFFF_FFF0_0800);
      write_reg(12'h202, 64'h10_0006);
      write_reg(12'h203, 64'h000F_FFFF_FFF0_0800);
      look_up(52'h10_0000);
      write_reg(12'h204, 64'h10_0001);
      write_reg(12'h205, 64'h000F_FFFF_FFF0_0800);
      look_up(52'h1F_FFFF);
      write_reg(12'h204, 64'h10_0000);
      write_reg(12'h205, 64'h0010_0000_0000_0800);
      write_reg(12'h206, 64'h10_0100);
      write_reg(12'h214, 64'h0);
      look_up(52'h1F_FFFF);
      look_up(52'hF_FFFF_FFFF_FFFF);

      for (int p = 0; p < 6; p++) begin
         wait_drained();
         csr_write(mtrr_pkg::CSR_VAR_COUNT, counts[p]);
         csr_write(mtrr_pkg::CSR_FIXED_SUP, {3'd0, sups[p]});
         settings_seen++;
         if (p == 5) quiet = 1;
         if (p == 2) hold_rsp = 1;
         for (int i = 0; i < 170; i++) begin
            random_request();
            if (i == 85 && p == 3) wait_drained();
            if (!quiet && $urandom_range(0, 7) == 0) idle($urandom_range(1, 10));
         end
      end

      req_push <= 1'b0;
      wait_cycles = 0;
      while (sb.expected_rsp.size() != 0 && wait_cycles < 10000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (20) @(posedge clock);
      if (sb.expected_rsp.size() != 0) begin
         $error("%0d responses never arrived", sb.expected_rsp.size());
         sb.errors++;
      end
      $display("ran %0d requests over %0d csr settings: %0d writes stored, %0d lookups",
               sb.n_requests, settings_seen, sb.n_accepted, sb.n_lookups);
      $display("lookups with conflicting variable types: %0d", sb.n_conflicts);
      if (sb.errors == 0) begin
         $display("mtrr_memory_type_resolver regression: pass");
      end else begin
         $display("mtrr_memory_type_resolver regression: fail");
      end
      $finish;
   end

endmodule

### sim.f
rtl/mtrr_pkg.sv
rtl/mtrr_front.sv
rtl/mtrr_back.sv
rtl/mtrr_memory_type_resolver.sv
rtl/mtrr_checker.sv
tb/testbench.sv
